>>> rtl/core/sha2h_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 / SHA-224 hasher package
// Round constants, initial values, register indexes and a rotate-right helper.
// ---------------------------------------------------------------------------
package sha2h_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGEST_BYTES = 8'd1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_word(input logic short_mode,
                                              input logic [2:0] idx);
        logic [31:0] v;
        case ({short_mode, idx})
            4'd0:  v = 32'h6a09e667; 4'd1:  v = 32'hbb67ae85;
            4'd2:  v = 32'h3c6ef372; 4'd3:  v = 32'ha54ff53a;
            4'd4:  v = 32'h510e527f; 4'd5:  v = 32'h9b05688c;
            4'd6:  v = 32'h1f83d9ab; 4'd7:  v = 32'h5be0cd19;
            4'd8:  v = 32'hc1059ed8; 4'd9:  v = 32'h367cd507;
            4'd10: v = 32'h3070dd17; 4'd11: v = 32'hf70e5939;
            4'd12: v = 32'hffc00b31; 4'd13: v = 32'h68581511;
            4'd14: v = 32'h64f98fa7; default: v = 32'hbefa4fa4;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    typedef logic [7:0][31:0] t_words;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic       load;    // copy hash words into working words
        logic       round;   // run one round
        logic       add;     // fold working words into hash words
        logic       init;    // load initial values
        logic       mode;
        logic [5:0] rnd;
        logic [31:0] w;
    } t_rctl;

endpackage

>>> rtl/core/sha2h_round.sv
// ---------------------------------------------------------------------------
// SHA-2 round datapath
// Holds hash and working words and applies one compression round a cycle while round is set.
// ---------------------------------------------------------------------------
module sha2h_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha2h_pkg::t_rctl   i_ctl,
    output sha2h_pkg::t_words  o_hash
);
    sha2h_pkg::t_words r_h, r_v;
    logic [31:0] t1, t2, s1, s0, ch, maj;

    always_comb begin
        s1  = sha2h_pkg::rotr(r_v[4], 6) ^ sha2h_pkg::rotr(r_v[4], 11)
            ^ sha2h_pkg::rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + s1 + ch + sha2h_pkg::round_k(i_ctl.rnd) + i_ctl.w;
        s0  = sha2h_pkg::rotr(r_v[0], 2) ^ sha2h_pkg::rotr(r_v[0], 13)
            ^ sha2h_pkg::rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = s0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha2h_pkg::init_word(i_rst_n ? i_ctl.mode : 1'b0, 3'(i));
            end
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
        if (i_ctl.load) begin
            r_v <= r_h;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash = r_h;
endmodule

>>> rtl/core/sha2h_sched.sv
// ---------------------------------------------------------------------------
// SHA-2 message schedule memory
// Sixteen schedule words in flip-flops; expansion word produced for the round.
// ---------------------------------------------------------------------------
module sha2h_sched (
    input  logic        i_clk,
    input  logic        i_wr,
    input  logic [3:0]  i_wr_idx,
    input  logic [31:0] i_wr_data,
    input  logic        i_step,
    input  logic [5:0]  i_rnd,
    output logic [31:0] o_w
);
    logic [15:0][31:0] r_w;
    logic [31:0] w2, w15, x;
    logic [3:0]  r4;

    always_comb begin
        r4  = i_rnd[3:0];
        w2  = r_w[r4 - 4'd2];
        w15 = r_w[r4 - 4'd15];
        x   = (sha2h_pkg::rotr(w2, 17) ^ sha2h_pkg::rotr(w2, 19) ^ (w2 >> 10))
            + r_w[r4 - 4'd7]
            + (sha2h_pkg::rotr(w15, 7) ^ sha2h_pkg::rotr(w15, 18) ^ (w15 >> 3))
            + r_w[r4];
        o_w = i_rnd[5:4] == 2'd0 ? r_w[r4] : x;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_w[i_wr_idx] <= i_wr_data;
        end else if (i_step && i_rnd[5:4] != 2'd0) begin
            r_w[r4] <= x;
        end
    end
endmodule

>>> rtl/core/sha256_sha224_hash.sv
// ---------------------------------------------------------------------------
// SHA-256 / SHA-224 byte-stream hasher
// Top level: byte buffer memory, padding and digest sequencer.
// ---------------------------------------------------------------------------
// Input transactions carry an optional message byte (tdata) with has_byte and
// end_of_message in tuser. Bytes are written into a 64-entry byte memory; a
// full block, and each padding block, is moved into the schedule registers
// four bytes at a time through the registered read port and then compressed
// with one round per cycle. A byte that fills a block therefore holds the
// input until that block is loaded, compressed and added into the hash words;
// other bytes leave the input ready for the next byte. The end of a
// message adds one or two blocks, after which digest bytes leave on the master
// side, one a transaction, last marked by tlast. A stalled receiver holds the
// digest byte in the output register; no new input is taken until the digest
// is out. Configuration writes (index 0: short_mode, index 1: digest_bytes)
// are taken at any cycle and should only be issued while idle. Reset loads
// the SHA-256 initial values, clears the byte count and selects a 32-byte
// digest.
// ---------------------------------------------------------------------------
module sha256_sha224_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // end_of_message (bit 1), has_byte (bit 0)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // digest_byte
    output logic        m_axis_tlast,   // last_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sha2h_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_RUN = 3'd2,
                           ST_ADD = 3'd3, ST_PAD = 3'd4, ST_OUT = 3'd5;

    logic [2:0]  r_st;
    logic        r_mode;
    logic [5:0]  r_dlen;
    logic [60:0] r_cnt;
    logic [5:0]  r_pos;       // padding pointer
    logic [6:0]  r_ld;        // load counter
    logic [5:0]  r_rnd;
    logic        r_fin;       // message ending: padding in progress
    logic        r_lenblk;    // current padded block carries the length
    logic [5:0]  r_oi, r_on;
    logic [23:0] r_acc;
    logic [7:0]  r_mem [64];
    logic [7:0]  r_rd;
    logic [7:0]  n_wdata;
    logic        n_we;
    logic [5:0]  n_waddr;
    logic [63:0] bits;
    sha2h_pkg::t_rctl  ctl;
    sha2h_pkg::t_words hash;
    logic [31:0] sch_w;
    logic        in_acc, cfg_acc, sch_wr;
    logic [5:0]  lim;

    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid;
    assign s_axis_tready = r_st == ST_IDLE;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign bits          = {r_cnt, 3'b000};
    assign lim           = r_mode ? 6'd28 : 6'd32;

    // Byte memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rd <= r_mem[r_ld[5:0]];
    end

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_pos;
        n_wdata = s_axis_tdata;
        if (r_st == ST_IDLE && in_acc && s_axis_tuser[0]) begin
            n_we    = 1'b1;
            n_waddr = r_cnt[5:0];
        end else if (r_st == ST_PAD) begin
            n_we = 1'b1;
            // In the block that carries the length, the top eight bytes are
            // always length, even where the marker sat there in the block
            // before.
            if (r_lenblk && r_pos >= 6'd56) begin
                n_wdata = bits[8*(7 - 32'(r_pos[2:0])) +: 8];
            end else if (r_pos == r_cnt[5:0]) begin
                n_wdata = sha2h_pkg::PAD_BYTE;
            end else begin
                n_wdata = 8'h00;
            end
        end
    end

    assign sch_wr = r_st == ST_LOAD && r_ld != 7'd0 && r_ld[1:0] == 2'd0;

    always_comb begin
        ctl       = '0;
        ctl.w     = sch_w;
        ctl.mode  = r_mode;
        ctl.rnd   = r_rnd;
        ctl.load  = r_st == ST_LOAD && r_ld == 7'd64;
        ctl.round = r_st == ST_RUN;
        ctl.add   = r_st == ST_ADD;
        ctl.init  = (cfg_acc && i_cfg_index == sha2h_pkg::REG_SHORT_MODE)
                  || (r_st == ST_OUT && r_oi == r_on);
        if (cfg_acc && i_cfg_index == sha2h_pkg::REG_SHORT_MODE) begin
            ctl.mode = i_cfg_data[0];
        end
    end

    sha2h_sched u_sched (
        .i_clk    (i_clk),
        .i_wr     (sch_wr),
        .i_wr_idx (4'(r_ld[5:2] - 4'd1)),
        .i_wr_data({r_acc, r_rd}),
        .i_step   (r_st == ST_RUN),
        .i_rnd    (r_rnd),
        .o_w      (sch_w)
    );

    sha2h_round u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .o_hash (hash)
    );

    always_ff @(posedge i_clk) begin
        if (r_st == ST_LOAD) begin
            r_acc <= {r_acc[15:0], r_rd};
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_mode <= 1'b0; r_dlen <= 6'd32; r_cnt <= '0;
            r_fin <= 1'b0; r_lenblk <= 1'b0; m_axis_tvalid <= 1'b0;
            r_pos <= '0; r_ld <= '0; r_rnd <= '0; r_oi <= '0; r_on <= '0;
        end else begin
            if (cfg_acc && i_cfg_index == sha2h_pkg::REG_SHORT_MODE) begin
                r_mode <= i_cfg_data[0];
                r_cnt  <= '0;
            end else if (cfg_acc && i_cfg_index == sha2h_pkg::REG_DIGEST_BYTES) begin
                r_dlen <= i_cfg_data[5:0];
            end
            case (r_st)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ld <= '0;
                        if (s_axis_tuser[0]) begin
                            r_cnt <= r_cnt + 61'd1;
                        end
                        if (s_axis_tuser[0] && r_cnt[5:0] == 6'd63) begin
                            r_fin    <= s_axis_tuser[1];
                            r_lenblk <= 1'b0;
                            r_st     <= ST_LOAD;
                        end else if (s_axis_tuser[1]) begin
                            r_fin <= 1'b1;
                            r_st  <= ST_PAD;
                            r_pos <= r_cnt[5:0] + 6'(s_axis_tuser[0]);
                            r_lenblk <= (r_cnt[5:0] + 6'(s_axis_tuser[0])) < 6'd56;
                        end
                    end
                end
                ST_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_ld <= '0;
                        r_st <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_ld <= r_ld + 7'd1;
                    if (r_ld == 7'd64) begin
                        r_rnd <= '0;
                        r_st  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_st <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (!r_fin) begin
                        r_st <= ST_IDLE;
                    end else if (!r_lenblk) begin
                        // One more block follows with the length; it also
                        // takes the marker when a full block ended the message.
                        r_lenblk <= 1'b1;
                        r_pos    <= 6'd0;
                        r_st     <= ST_PAD;
                    end else begin
                        r_fin <= 1'b0;
                        r_oi  <= '0;
                        r_on  <= r_dlen < lim ? r_dlen : lim;
                        r_st  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        if (r_oi == r_on) begin
                            m_axis_tvalid <= 1'b0;
                            r_cnt <= '0;
                            r_st  <= ST_IDLE;
                        end else begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata  <= hash[r_oi[4:2]][8*(3 - 32'(r_oi[1:0])) +: 8];
                            m_axis_tlast  <= r_oi + 6'd1 == r_on;
                            r_oi <= r_oi + 6'd1;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/sha2h_checker.sv
// ---------------------------------------------------------------------------
// SHA-2 hasher port checker
// Watches the top-level ports for ordering rules of the digest stream.
// ---------------------------------------------------------------------------
module sha2h_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("digest byte dropped while stalled");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while digest pending");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind sha256_sha224_hash sha2h_checker u_sha2h_checker (.*);
